// ----- src/esp_pkg.sv -----
// ----------------------------------------------------------------------------
// esp_pkg
// Shared types and constants of the elite solution pool: entry layout,
// widths, the compare unit's result bundle and the stream word layouts.
// ----------------------------------------------------------------------------
package esp_pkg;

  // Pool geometry
  localparam int POOL_DEPTH = 8;
  localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

  // Field widths
  localparam int COST_W  = 48;
  localparam int PAY_W   = 32;
  localparam int STAMP_W = 32;
  localparam int DRAW_W  = 16;
  localparam int TOL_W   = 16;
  localparam int BIT_W   = $clog2(DRAW_W);

  // Stream word widths
  localparam int IN_W    = 128;
  localparam int IN_U_W  = 2;
  localparam int OUT_W   = 120;
  localparam int OUT_PAD = OUT_W - (3 + PAY_W + 4 + COST_W + STAMP_W);

  // Reset values
  localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(66);
  localparam logic [COST_W-1:0] COST_NONE  = {COST_W{1'b1}};

  // Action codes
  localparam logic ACT_PUBLISH = 1'b0;
  localparam logic ACT_FETCH   = 1'b1;

  typedef logic [COST_W-1:0] cost_t;
  typedef logic [PAY_W-1:0]  pay_t;

  // One pool entry
  typedef struct packed {
    cost_t cost;
    pay_t  payload;
  } entry_t;

  // Result of the shared compare unit
  typedef struct packed {
    logic  lt;    // a < b
    logic  near;  // |a - b| < tolerance
    cost_t absd;  // |a - b|
  } cmp_res_t;

endpackage

// ----- src/esp_cmp.sv -----
// ----------------------------------------------------------------------------
// esp_cmp
// Shared subtract and compare unit: ordering, absolute distance and the
// duplicate test against the diversity tolerance.
// ----------------------------------------------------------------------------
module esp_cmp (
  input  esp_pkg::cost_t            a,
  input  esp_pkg::cost_t            b,
  input  logic [esp_pkg::TOL_W-1:0] tol,
  output esp_pkg::cmp_res_t         res
);
  import esp_pkg::*;

  logic [COST_W:0] diff;
  cost_t           absd;

  // Subtract once, fold the sign into a magnitude
  assign diff = {1'b0, a} - {1'b0, b};
  assign absd = diff[COST_W] ? (cost_t'(0) - diff[COST_W-1:0]) : diff[COST_W-1:0];

  assign res.lt   = diff[COST_W];
  assign res.absd = absd;
  assign res.near = (absd < {{(COST_W-TOL_W){1'b0}}, tol});

endmodule

// ----- src/elite_solution_pool_unit.sv -----
// ----------------------------------------------------------------------------
// elite_solution_pool_unit
// Sorted pool of the best candidate solutions with duplicate rejection,
// best-cost tracking and best or random fetch.
// ----------------------------------------------------------------------------
// A word is taken only while the block is idle, then it runs on its own until
// the result is loaded into the output register; the next word can be taken
// while that result waits. Everything passes through one shared 48-bit
// subtract/compare unit and one entry memory with one write port and one
// registered read port. A publish scans the stored entries for a near
// duplicate, shifts larger entries toward the tail and drops the candidate
// in the hole, then checks the best cost when it lands at the head; a
// rejected duplicate ends early. A best fetch reads the head entry, an
// empty-pool fetch goes straight to the output, and a random fetch first
// reduces the 16-bit draw modulo the entry count bit-serially. A result
// waits for a free output register. No clearing pass after reset.
// ----------------------------------------------------------------------------
module elite_solution_pool_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // Configuration: diversity_tolerance
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [esp_pkg::TOL_W-1:0]   cfg_data,
  // Input words
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [47:0] cost, [79:48] payload_in, [111:80] timestamp, [127:112] random_draw
  input  logic [esp_pkg::IN_W-1:0]    in_tdata,
  // [0] action, [1] want_best
  input  logic [esp_pkg::IN_U_W-1:0]  in_tuser,
  // Result words
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [0] accepted, [1] new_best, [2] found, [34:3] payload_out,
  // [38:35] pool_count, [86:39] best_cost, [118:87] best_time, [119] zero
  output logic [esp_pkg::OUT_W-1:0]   out_tdata
);
  import esp_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_INS   = 7'b0000100,
    S_BEST  = 7'b0001000,
    S_MOD   = 7'b0010000,
    S_FETCH = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  cost_t                cost_r, cost_nxt;
  pay_t                 pay_r, pay_nxt;
  logic [STAMP_W-1:0]   stamp_r, stamp_nxt;
  logic [DRAW_W-1:0]    draw_r, draw_nxt;
  logic [TOL_W-1:0]     tol_r, tol_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  cost_t                best_r, best_nxt;
  logic [STAMP_W-1:0]   btime_r, btime_nxt;
  logic [IDX_W-1:0]     scan_r, scan_nxt;
  logic [IDX_W-1:0]     k_r, k_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic                 res_acc_r, res_acc_nxt;
  logic                 res_nb_r, res_nb_nxt;
  logic                 res_found_r, res_found_nxt;
  pay_t                 res_pay_r, res_pay_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r, out_data_nxt;

  // Entry memory
  entry_t               mem [POOL_DEPTH];
  entry_t               rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;

  // Shared compare unit
  cost_t                cmp_a, cmp_b;
  cmp_res_t             cmp;

  logic                 in_fire;
  logic                 scan_last;
  logic                 pool_full;
  logic [IDX_W-1:0]     ins_k;
  logic [CNT_W:0]       rem_sh;

  esp_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .tol (tol_r),
    .res (cmp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign pool_full = (cnt_r == CNT_W'(POOL_DEPTH));
  assign scan_last = ({{(CNT_W-IDX_W){1'b0}}, scan_r} + CNT_W'(1)) == cnt_r;
  assign ins_k     = pool_full ? IDX_W'(POOL_DEPTH - 1) : IDX_W'(cnt_r);
  assign rem_sh    = {rem_r, draw_r[bit_r]};

  // Select compare operands
  always_comb begin
    cmp_a = cost_r;
    cmp_b = rd_data_r.cost;
    if (state_r == S_MOD) begin
      cmp_a = COST_W'(rem_sh);
      cmp_b = COST_W'(cnt_r);
    end else if (state_r == S_BEST) begin
      cmp_b = best_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cost_nxt      = cost_r;
    pay_nxt       = pay_r;
    stamp_nxt     = stamp_r;
    draw_nxt      = draw_r;
    tol_nxt       = cfg_valid ? cfg_data : tol_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    btime_nxt     = btime_r;
    scan_nxt      = scan_r;
    k_nxt         = k_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    res_acc_nxt   = res_acc_r;
    res_nb_nxt    = res_nb_r;
    res_found_nxt = res_found_r;
    res_pay_nxt   = res_pay_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = k_r;
    wr_data       = '{cost: cost_r, payload: pay_r};

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cost_nxt      = in_tdata[COST_W-1:0];
          pay_nxt       = in_tdata[COST_W +: PAY_W];
          stamp_nxt     = in_tdata[COST_W+PAY_W +: STAMP_W];
          draw_nxt      = in_tdata[COST_W+PAY_W+STAMP_W +: DRAW_W];
          res_acc_nxt   = 1'b0;
          res_nb_nxt    = 1'b0;
          res_found_nxt = 1'b0;
          res_pay_nxt   = '0;
          scan_nxt      = '0;
          rem_nxt       = '0;
          bit_nxt       = BIT_W'(DRAW_W - 1);
          if (in_tuser[0] == ACT_PUBLISH) begin
            if (cnt_r == '0) begin
              k_nxt     = '0;
              cnt_nxt   = CNT_W'(1);
              state_nxt = S_INS;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            priority if (cnt_r == '0) begin
              state_nxt = S_OUT;
            end else if (in_tuser[1]) begin
              state_nxt = S_FETCH;
            end else begin
              state_nxt = S_MOD;
            end
          end
        end
      end

      // Walk stored costs, reject on a near duplicate
      S_SCAN: begin
        rd_addr = scan_last ? (ins_k - IDX_W'(1)) : (scan_r + IDX_W'(1));
        priority if (cmp.near) begin
          state_nxt = S_OUT;
        end else if (!scan_last) begin
          scan_nxt = scan_r + IDX_W'(1);
        end else if (!pool_full) begin
          k_nxt     = ins_k;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_INS;
        end else if (cmp.lt) begin
          k_nxt     = ins_k;
          state_nxt = S_INS;
        end else begin
          state_nxt = S_OUT;
        end
      end

      // Shift larger entries toward the tail, drop the candidate in the hole
      S_INS: begin
        rd_addr = k_r - IDX_W'(2);
        wr_en   = 1'b1;
        if (k_r != '0 && cmp.lt) begin
          wr_data = rd_data_r;
          k_nxt   = k_r - IDX_W'(1);
        end else begin
          res_acc_nxt = 1'b1;
          state_nxt   = (k_r == '0) ? S_BEST : S_OUT;
        end
      end

      // Record a new head cost that beats the best seen
      S_BEST: begin
        if (cmp.lt) begin
          best_nxt   = cost_r;
          btime_nxt  = stamp_r;
          res_nb_nxt = 1'b1;
        end
        state_nxt = S_OUT;
      end

      // Reduce the draw modulo the count, one bit per cycle
      S_MOD: begin
        rem_nxt = cmp.lt ? CNT_W'(rem_sh) : CNT_W'(cmp.absd);
        rd_addr = IDX_W'(rem_nxt);
        if (bit_r == '0) begin
          state_nxt = S_FETCH;
        end else begin
          bit_nxt = bit_r - BIT_W'(1);
        end
      end

      S_FETCH: begin
        res_found_nxt = 1'b1;
        res_pay_nxt   = rd_data_r.payload;
        state_nxt     = S_OUT;
      end

      // Load the output register once it is free
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{OUT_PAD{1'b0}}, btime_r, best_r, 4'(cnt_r), res_pay_r,
                           res_found_r, res_nb_r, res_acc_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tol_r       <= TOL_RESET;
      cnt_r       <= '0;
      best_r      <= COST_NONE;
      btime_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tol_r       <= tol_nxt;
      cnt_r       <= cnt_nxt;
      best_r      <= best_nxt;
      btime_r     <= btime_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    cost_r      <= cost_nxt;
    pay_r       <= pay_nxt;
    stamp_r     <= stamp_nxt;
    draw_r      <= draw_nxt;
    scan_r      <= scan_nxt;
    k_r         <= k_nxt;
    rem_r       <= rem_nxt;
    bit_r       <= bit_nxt;
    res_acc_r   <= res_acc_nxt;
    res_nb_r    <= res_nb_nxt;
    res_found_r <= res_found_nxt;
    res_pay_r   <= res_pay_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule
